// ===== sv/lrfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrfs_pkg
// Shared types, constants and byte helpers for the LCD rectangle fill sequencer.
// ----------------------------------------------------------------------------
package lrfs_pkg;

	localparam int unsigned CoordW    = 8;
	localparam int unsigned ColorW    = 12;
	localparam int unsigned ByteW     = 8;
	localparam int unsigned PhaseW    = 4;
	localparam int unsigned GroupW    = 16;
	localparam int unsigned CfgIdxW   = 2;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_COLUMN_SET   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PAGE_SET     = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MEMORY_WRITE = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_NO_OPERATION = 2'd3;

	// Opcode reset values
	localparam logic [ByteW-1:0] COLUMN_SET_RESET   = 8'd42;
	localparam logic [ByteW-1:0] PAGE_SET_RESET     = 8'd43;
	localparam logic [ByteW-1:0] MEMORY_WRITE_RESET = 8'd44;
	localparam logic [ByteW-1:0] NO_OPERATION_RESET = 8'd0;

	// Item op codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_FILL = 1'b1;

	// Sequencer phases
	localparam logic [PhaseW-1:0] PH_COL_CMD   = 4'd0;
	localparam logic [PhaseW-1:0] PH_XLOW      = 4'd1;
	localparam logic [PhaseW-1:0] PH_XHIGH     = 4'd2;
	localparam logic [PhaseW-1:0] PH_PAGE_CMD  = 4'd3;
	localparam logic [PhaseW-1:0] PH_YLOW      = 4'd4;
	localparam logic [PhaseW-1:0] PH_YHIGH     = 4'd5;
	localparam logic [PhaseW-1:0] PH_WRITE_CMD = 4'd6;
	localparam logic [PhaseW-1:0] PH_PIXELS    = 4'd7;
	localparam logic [PhaseW-1:0] PH_CLOSE     = 4'd8;

	// Byte position inside a pixel-pair group
	localparam logic [1:0] GRP_BYTE0 = 2'd0;
	localparam logic [1:0] GRP_BYTE1 = 2'd1;

	typedef struct packed {
		logic              op;
		logic [CoordW-1:0] corner_a_x;
		logic [CoordW-1:0] corner_a_y;
		logic [CoordW-1:0] corner_b_x;
		logic [CoordW-1:0] corner_b_y;
		logic [ColorW-1:0] fill_color;
	} in_item_t;

	typedef struct packed {
		logic             is_data;
		logic [ByteW-1:0] word_byte;
		logic             last;
	} out_word_t;

	typedef struct packed {
		logic [ByteW-1:0] column_set_opcode;
		logic [ByteW-1:0] page_set_opcode;
		logic [ByteW-1:0] memory_write_opcode;
		logic [ByteW-1:0] no_operation_opcode;
	} cfg_t;

	// Bytes of a 4:4:4 pixel pair, both pixels the same color
	function automatic logic [ByteW-1:0] pair_byte0(input logic [ColorW-1:0] c);
		return c[11:4];
	endfunction

	function automatic logic [ByteW-1:0] pair_byte1(input logic [ColorW-1:0] c);
		return {c[3:0], c[11:8]};
	endfunction

	function automatic logic [ByteW-1:0] pair_byte2(input logic [ColorW-1:0] c);
		return c[7:0];
	endfunction

endpackage

// ===== sv/lrfs_stream_if.sv =====
// ----------------------------------------------------------------------------
// lrfs_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface lrfs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/lrfs_core.sv =====
// ----------------------------------------------------------------------------
// lrfs_core
// Fill sequencer state: latches a rectangle on a fill while idle, emits one word per tick while busy.
// ----------------------------------------------------------------------------
module lrfs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  lrfs_pkg::in_item_t  item,
	input  lrfs_pkg::cfg_t      cfg,
	output logic                has_result,
	output lrfs_pkg::out_word_t result
);

	logic                              busy_q;
	logic [lrfs_pkg::PhaseW-1:0]       phase_q;
	logic [lrfs_pkg::GroupW-1:0]       groups_q;
	logic [1:0]                        byte_q;
	logic [lrfs_pkg::CoordW-1:0]       x_low_q, x_high_q, y_low_q, y_high_q;
	logic [lrfs_pkg::ColorW-1:0]       color_q;

	logic [lrfs_pkg::CoordW-1:0]       x_lo, x_hi, y_lo, y_hi;
	logic [lrfs_pkg::CoordW:0]         width, height;
	logic [2*lrfs_pkg::CoordW:0]       area;
	logic [lrfs_pkg::GroupW-1:0]       groups_init;
	logic [lrfs_pkg::GroupW-1:0]       groups_dec;
	logic                              do_fill;
	logic                              do_tick;

	assign do_fill = step_en && (item.op == lrfs_pkg::OP_FILL) && !busy_q;
	assign do_tick = step_en && (item.op == lrfs_pkg::OP_TICK) && busy_q;

	// Sort corners and size the pixel-pair count
	always_comb begin
		x_lo        = (item.corner_a_x <= item.corner_b_x) ? item.corner_a_x : item.corner_b_x;
		x_hi        = (item.corner_a_x <= item.corner_b_x) ? item.corner_b_x : item.corner_a_x;
		y_lo        = (item.corner_a_y <= item.corner_b_y) ? item.corner_a_y : item.corner_b_y;
		y_hi        = (item.corner_a_y <= item.corner_b_y) ? item.corner_b_y : item.corner_a_y;
		width       = {1'b0, x_hi} - {1'b0, x_lo} + 9'd1;
		height      = {1'b0, y_hi} - {1'b0, y_lo} + 9'd1;
		area        = 17'(width) * 17'(height);
		groups_init = area[2*lrfs_pkg::CoordW:1] + 16'd1;
	end

	assign groups_dec = groups_q - 16'd1;
	assign has_result = (item.op == lrfs_pkg::OP_TICK) && busy_q;

	always_comb begin
		result = '0;
		case (phase_q)
			lrfs_pkg::PH_COL_CMD: begin
				result.word_byte = cfg.column_set_opcode;
			end
			lrfs_pkg::PH_XLOW: begin
				result.is_data   = 1'b1;
				result.word_byte = x_low_q;
			end
			lrfs_pkg::PH_XHIGH: begin
				result.is_data   = 1'b1;
				result.word_byte = x_high_q;
			end
			lrfs_pkg::PH_PAGE_CMD: begin
				result.word_byte = cfg.page_set_opcode;
			end
			lrfs_pkg::PH_YLOW: begin
				result.is_data   = 1'b1;
				result.word_byte = y_low_q;
			end
			lrfs_pkg::PH_YHIGH: begin
				result.is_data   = 1'b1;
				result.word_byte = y_high_q;
			end
			lrfs_pkg::PH_WRITE_CMD: begin
				result.word_byte = cfg.memory_write_opcode;
			end
			lrfs_pkg::PH_PIXELS: begin
				result.is_data = 1'b1;
				if (byte_q == lrfs_pkg::GRP_BYTE0) begin
					result.word_byte = lrfs_pkg::pair_byte0(color_q);
				end else if (byte_q == lrfs_pkg::GRP_BYTE1) begin
					result.word_byte = lrfs_pkg::pair_byte1(color_q);
				end else begin
					result.word_byte = lrfs_pkg::pair_byte2(color_q);
				end
			end
			default: begin
				// closing phase; unreachable codes behave the same
				result.word_byte = cfg.no_operation_opcode;
				result.last      = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			phase_q  <= lrfs_pkg::PH_COL_CMD;
			groups_q <= '0;
			byte_q   <= lrfs_pkg::GRP_BYTE0;
		end else if (do_fill) begin
			busy_q   <= 1'b1;
			phase_q  <= lrfs_pkg::PH_COL_CMD;
			groups_q <= groups_init;
			byte_q   <= lrfs_pkg::GRP_BYTE0;
		end else if (do_tick) begin
			case (phase_q)
				lrfs_pkg::PH_COL_CMD, lrfs_pkg::PH_XLOW, lrfs_pkg::PH_XHIGH,
				lrfs_pkg::PH_PAGE_CMD, lrfs_pkg::PH_YLOW, lrfs_pkg::PH_YHIGH,
				lrfs_pkg::PH_WRITE_CMD: begin
					phase_q <= phase_q + 4'd1;
				end
				lrfs_pkg::PH_PIXELS: begin
					if (byte_q == lrfs_pkg::GRP_BYTE0 || byte_q == lrfs_pkg::GRP_BYTE1) begin
						byte_q <= byte_q + 2'd1;
					end else begin
						byte_q   <= lrfs_pkg::GRP_BYTE0;
						groups_q <= groups_dec;
						if (groups_dec == '0) begin
							phase_q <= lrfs_pkg::PH_CLOSE;
						end
					end
				end
				default: begin
					busy_q   <= 1'b0;
					phase_q  <= lrfs_pkg::PH_COL_CMD;
					groups_q <= '0;
					byte_q   <= lrfs_pkg::GRP_BYTE0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_fill) begin
			x_low_q  <= x_lo;
			x_high_q <= x_hi;
			y_low_q  <= y_lo;
			y_high_q <= y_hi;
			color_q  <= item.fill_color;
		end
	end

`ifndef NO_ASSERTIONS
	a_last_ends_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(do_tick && result.last) |=> !busy_q)
		else $error("sequencer still busy after closing word");

	a_fill_starts_at_col: assert property (@(posedge clk) disable iff (!arst_n)
		do_fill |=> (busy_q && phase_q == lrfs_pkg::PH_COL_CMD))
		else $error("fill did not start the column command");

	a_pixels_have_groups: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && phase_q == lrfs_pkg::PH_PIXELS) |-> (groups_q != '0))
		else $error("pixel phase with no groups left");

	a_busy_holds_on_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && item.op == lrfs_pkg::OP_FILL && busy_q) |=> $stable(phase_q))
		else $error("fill while busy changed the phase");
`endif

endmodule

// ===== sv/lcd_rect_fill_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// lcd_rect_fill_sequencer_unit
// Controller word stream generator for one-color rectangle fills.
// ----------------------------------------------------------------------------
// One item is accepted per clock when results are taken each clock; a result
// passes the input register, then the output register, before it leaves. The
// sequencer core steps once per item. A fill item gives no word; each later
// tick gives one word until the closing no-op marked last. The user must
// write the opcode registers through wr_en, wr_index and wr_data only while
// the unit is idle; the unit itself does not enforce this.
module lcd_rect_fill_sequencer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	lrfs_stream_if.sink                   cmd,
	lrfs_stream_if.source                 word,
	input  logic                          wr_en,
	input  logic [lrfs_pkg::CfgIdxW-1:0]  wr_index,
	input  logic [lrfs_pkg::ByteW-1:0]    wr_data
);

	lrfs_pkg::cfg_t      cfg_q;
	logic                valid_s1;
	lrfs_pkg::in_item_t  item_s1;
	logic                out_valid_q;
	lrfs_pkg::out_word_t out_word_q;

	logic                has_result;
	lrfs_pkg::out_word_t result;
	logic                advance;

	assign advance   = valid_s1 && (!has_result || !out_valid_q || word.ready);
	assign cmd.ready = !valid_s1 || advance;

	assign word.valid   = out_valid_q;
	assign word.payload = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.column_set_opcode   <= lrfs_pkg::COLUMN_SET_RESET;
			cfg_q.page_set_opcode     <= lrfs_pkg::PAGE_SET_RESET;
			cfg_q.memory_write_opcode <= lrfs_pkg::MEMORY_WRITE_RESET;
			cfg_q.no_operation_opcode <= lrfs_pkg::NO_OPERATION_RESET;
		end else if (wr_en) begin
			case (wr_index)
				lrfs_pkg::REG_COLUMN_SET:   cfg_q.column_set_opcode   <= wr_data;
				lrfs_pkg::REG_PAGE_SET:     cfg_q.page_set_opcode     <= wr_data;
				lrfs_pkg::REG_MEMORY_WRITE: cfg_q.memory_write_opcode <= wr_data;
				lrfs_pkg::REG_NO_OPERATION: cfg_q.no_operation_opcode <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && has_result) begin
				out_valid_q <= 1'b1;
			end else if (word.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.payload;
		end
		if (advance && has_result) begin
			out_word_q <= result;
		end
	end

	lrfs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.item       (item_s1),
		.cfg        (cfg_q),
		.has_result (has_result),
		.result     (result)
	);

`ifndef NO_ASSERTIONS
	a_result_registered: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has_result) |=> out_valid_q)
		else $error("word lost on the way to the output register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !word.ready) |-> !(advance && has_result))
		else $error("pending output word overwritten");

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !has_result) |-> advance)
		else $error("item without a word stalled in the input register");
`endif

endmodule

// ===== verif/tb_lcd_rect_fill_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lcd_rect_fill_sequencer_unit
// Self-checking bench for the rectangle fill word sequencer. A queue-fed
// driver sends fill and tick items while a monitor compares every word
// transfer with a behavioral copy of the sequencer. Random stalls are applied
// on both channels. The opcode registers are rewritten between test phases.
// ----------------------------------------------------------------------------
module tb_lcd_rect_fill_sequencer_unit;
	import lrfs_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_PRINTED   = 40;
	localparam int RUN_LIMIT     = 2_000_000;
	localparam logic [1:0] GRP_BYTE2 = 2'd2;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CfgIdxW-1:0] wr_index;
	logic [ByteW-1:0] wr_data;

	lrfs_stream_if #(.payload_t(in_item_t))  cmd_if ();
	lrfs_stream_if #(.payload_t(out_word_t)) word_if ();

	lcd_rect_fill_sequencer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_if),
		.word     (word_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// stimulus side
	in_item_t cmd_pending[$];
	bit       plan_busy;
	int       plan_words_left;
	int       plan_count;
	int       idle_pct;
	int       send_gap;
	int       take_stall;
	logic     cmd_taken;

	// expected behavior
	out_word_t         expected_words[$];
	cfg_t              model_cfg;
	logic              seq_busy;
	logic [PhaseW-1:0] seq_phase;
	logic [CoordW-1:0] seq_x_lo, seq_x_hi, seq_y_lo, seq_y_hi;
	logic [ColorW-1:0] seq_color;
	logic [GroupW-1:0] seq_groups;
	logic [1:0]        seq_byte;
	int                mismatch_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT);
		$display("lcd_rect_fill_sequencer_unit test failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic step_fill_sequencer(input in_item_t it);
		out_word_t w;
		int span_x, span_y;
		logic [ColorW-1:0] c;
		c = seq_color;
		if (it.op == OP_FILL) begin
			if (!seq_busy) begin
				seq_x_lo = (it.corner_a_x <= it.corner_b_x) ? it.corner_a_x : it.corner_b_x;
				seq_x_hi = (it.corner_a_x > it.corner_b_x) ? it.corner_a_x : it.corner_b_x;
				seq_y_lo = (it.corner_a_y <= it.corner_b_y) ? it.corner_a_y : it.corner_b_y;
				seq_y_hi = (it.corner_a_y > it.corner_b_y) ? it.corner_a_y : it.corner_b_y;
				seq_color = it.fill_color;
				span_x = int'(seq_x_hi) - int'(seq_x_lo) + 1;
				span_y = int'(seq_y_hi) - int'(seq_y_lo) + 1;
				seq_groups = GroupW'((span_x * span_y) / 2 + 1);
				seq_byte = GRP_BYTE0;
				seq_phase = PH_COL_CMD;
				seq_busy = 1'b1;
			end
		end else if (seq_busy) begin
			w = '0;
			case (seq_phase)
				PH_COL_CMD: begin
					w.word_byte = model_cfg.column_set_opcode;
					seq_phase = seq_phase + 4'd1;
				end
				PH_XLOW: begin
					w.is_data = 1'b1;
					w.word_byte = seq_x_lo;
					seq_phase = seq_phase + 4'd1;
				end
				PH_XHIGH: begin
					w.is_data = 1'b1;
					w.word_byte = seq_x_hi;
					seq_phase = seq_phase + 4'd1;
				end
				PH_PAGE_CMD: begin
					w.word_byte = model_cfg.page_set_opcode;
					seq_phase = seq_phase + 4'd1;
				end
				PH_YLOW: begin
					w.is_data = 1'b1;
					w.word_byte = seq_y_lo;
					seq_phase = seq_phase + 4'd1;
				end
				PH_YHIGH: begin
					w.is_data = 1'b1;
					w.word_byte = seq_y_hi;
					seq_phase = seq_phase + 4'd1;
				end
				PH_WRITE_CMD: begin
					w.word_byte = model_cfg.memory_write_opcode;
					seq_phase = seq_phase + 4'd1;
				end
				PH_PIXELS: begin
					w.is_data = 1'b1;
					case (seq_byte)
						GRP_BYTE0: w.word_byte = c[11:4];
						GRP_BYTE1: w.word_byte = {c[3:0], c[11:8]};
						default:   w.word_byte = c[7:0];
					endcase
					if (seq_byte >= GRP_BYTE2) begin
						seq_byte = GRP_BYTE0;
						seq_groups = seq_groups - 16'd1;
						if (seq_groups == '0)
							seq_phase = PH_CLOSE;
					end else begin
						seq_byte = seq_byte + 2'd1;
					end
				end
				default: begin
					// closing no-op; unused phase codes act the same way
					w.word_byte = model_cfg.no_operation_opcode;
					w.last = 1'b1;
					seq_busy = 1'b0;
					seq_phase = PH_COL_CMD;
					seq_byte = GRP_BYTE0;
					seq_groups = '0;
				end
			endcase
			expected_words.push_back(w);
		end
	endtask

	// check the output transfer first: a word never belongs to an item
	// accepted at the same edge
	always @(posedge clk) begin : observe
		out_word_t got, want;
		cmd_taken <= arst_n && cmd_if.valid && cmd_if.ready;
		if (arst_n) begin
			if (word_if.valid && word_if.ready) begin
				got = word_if.payload;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word %0b/%02h/%0b",
						got.is_data, got.word_byte, got.last));
				end else begin
					want = expected_words.pop_front();
					if (got.is_data !== want.is_data)
						report_mismatch($sformatf("is_data got %0b expected %0b",
							got.is_data, want.is_data));
					if (got.word_byte !== want.word_byte)
						report_mismatch($sformatf("word_byte got %02h expected %02h",
							got.word_byte, want.word_byte));
					if (got.last !== want.last)
						report_mismatch($sformatf("last got %0b expected %0b",
							got.last, want.last));
				end
			end
			if (cmd_if.valid && cmd_if.ready)
				step_fill_sequencer(cmd_if.payload);
		end
	end

	always @(negedge clk) begin : drive_cmd
		logic next_valid;
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
		end else if (!cmd_if.valid || cmd_taken) begin
			next_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (cmd_pending.size() != 0) begin
				if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
					send_gap = $urandom_range(1, 17) - 1;
				end else begin
					next_valid = 1'b1;
					cmd_if.payload <= cmd_pending.pop_front();
				end
			end
			cmd_if.valid <= next_valid;
		end
	end

	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			word_if.ready <= 1'b0;
		end else if (take_stall > 0) begin
			take_stall--;
			word_if.ready <= 1'b0;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			take_stall = $urandom_range(1, 17) - 1;
			word_if.ready <= 1'b0;
		end else begin
			word_if.ready <= 1'b1;
		end
	end

	function automatic in_item_t random_item(input logic op);
		in_item_t it;
		it.op = op;
		it.corner_a_x = CoordW'($urandom_range(0, 255));
		it.corner_a_y = CoordW'($urandom_range(0, 255));
		it.corner_b_x = CoordW'($urandom_range(0, 255));
		it.corner_b_y = CoordW'($urandom_range(0, 255));
		it.fill_color = ColorW'($urandom_range(0, 4095));
		return it;
	endfunction

	// queue one item and track what the sequencer will be doing with it
	task automatic plan_item(input in_item_t it);
		int w, h;
		cmd_pending.push_back(it);
		if (it.op == OP_FILL) begin
			if (!plan_busy) begin
				w = (it.corner_a_x > it.corner_b_x) ? it.corner_a_x - it.corner_b_x
					: it.corner_b_x - it.corner_a_x;
				h = (it.corner_a_y > it.corner_b_y) ? it.corner_a_y - it.corner_b_y
					: it.corner_b_y - it.corner_a_y;
				plan_words_left = 8 + 3 * (((w + 1) * (h + 1)) / 2 + 1);
				plan_busy = 1'b1;
				plan_count++;
			end
		end else if (plan_busy) begin
			plan_count++;
			plan_words_left--;
			if (plan_words_left == 0)
				plan_busy = 1'b0;
		end
	endtask

	task automatic plan_fill(input int ax, input int ay, input int bx, input int by,
			input int color);
		in_item_t it;
		it = random_item(OP_FILL);
		it.corner_a_x = CoordW'(ax);
		it.corner_a_y = CoordW'(ay);
		it.corner_b_x = CoordW'(bx);
		it.corner_b_y = CoordW'(by);
		it.fill_color = ColorW'(color);
		plan_item(it);
	endtask

	task automatic plan_ticks(input int n);
		repeat (n) plan_item(random_item(OP_TICK));
	endtask

	task automatic plan_to_close();
		while (plan_busy)
			plan_item(random_item(OP_TICK));
	endtask

	function automatic int near_coord(input int base);
		int d, v;
		d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
		v = $urandom_range(0, 1) ? base + d : base - d;
		if (v > 255 || v < 0)
			v = (v > 255) ? base - d : base + d;
		return v;
	endfunction

	task automatic plan_random_round();
		int pick, ax, ay, cut;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			plan_ticks($urandom_range(1, 3));
		end else begin
			ax = $urandom_range(0, 255);
			ay = $urandom_range(0, 255);
			plan_fill(ax, ay, near_coord(ax), near_coord(ay), $urandom_range(0, 4095));
			if (pick == 1) begin
				// cut short; the next round's fill lands while busy
				cut = $urandom_range(0, plan_words_left - 1);
				plan_ticks(cut);
			end else begin
				while (plan_busy) begin
					if ($urandom_range(0, 39) == 0)
						plan_item(random_item(OP_FILL));
					else
						plan_item(random_item(OP_TICK));
				end
			end
		end
	endtask

	task automatic plan_random_phase(input int target);
		int start;
		start = plan_count;
		while (plan_count - start < target)
			plan_random_round();
		plan_to_close();
	endtask

	task automatic wait_idle();
		while (cmd_pending.size() != 0 || cmd_if.valid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_opcodes(input cfg_t c);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_COLUMN_SET;
		wr_data <= c.column_set_opcode;
		@(negedge clk);
		wr_index <= REG_PAGE_SET;
		wr_data <= c.page_set_opcode;
		@(negedge clk);
		wr_index <= REG_MEMORY_WRITE;
		wr_data <= c.memory_write_opcode;
		@(negedge clk);
		wr_index <= REG_NO_OPERATION;
		wr_data <= c.no_operation_opcode;
		@(negedge clk);
		wr_en <= 1'b0;
		model_cfg = c;
	endtask

	initial begin : main
		in_item_t it;
		cfg_t c;
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		cmd_if.valid = 1'b0;
		cmd_if.payload = '0;
		word_if.ready = 1'b0;
		cmd_taken = 1'b0;
		send_gap = 0;
		take_stall = 0;
		plan_busy = 1'b0;
		plan_words_left = 0;
		plan_count = 0;
		mismatch_count = 0;
		idle_pct = 10;
		model_cfg.column_set_opcode = COLUMN_SET_RESET;
		model_cfg.page_set_opcode = PAGE_SET_RESET;
		model_cfg.memory_write_opcode = MEMORY_WRITE_RESET;
		model_cfg.no_operation_opcode = NO_OPERATION_RESET;
		seq_busy = 1'b0;
		seq_phase = PH_COL_CMD;
		seq_x_lo = '0;
		seq_x_hi = '0;
		seq_y_lo = '0;
		seq_y_hi = '0;
		seq_color = '0;
		seq_groups = '0;
		seq_byte = GRP_BYTE0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset opcodes, idle ticks, corner extremes, busy fill
		it = '1;
		it.op = OP_TICK;
		plan_item(it);
		plan_ticks(1);
		plan_fill(0, 0, 0, 0, 12'hFFF);
		plan_ticks(3);
		plan_item(random_item(OP_FILL));
		plan_to_close();
		plan_fill(255, 255, 255, 255, 12'h000);
		plan_to_close();
		plan_fill(255, 200, 0, 200, 12'hA5C);
		plan_to_close();
		plan_fill(10, 20, 12, 20, 12'h5A3);
		plan_to_close();
		plan_fill(4, 4, 3, 3, 12'h3C6);
		plan_to_close();
		plan_ticks(2);
		wait_idle();

		c = '1;
		write_opcodes(c);
		idle_pct = 30;
		plan_random_phase(150);
		wait_idle();

		c = '0;
		write_opcodes(c);
		idle_pct = 0;
		plan_random_phase(150);
		wait_idle();

		c.column_set_opcode = ByteW'($urandom_range(0, 255));
		c.page_set_opcode = ByteW'($urandom_range(0, 255));
		c.memory_write_opcode = ByteW'($urandom_range(0, 255));
		c.no_operation_opcode = ByteW'($urandom_range(0, 255));
		write_opcodes(c);
		idle_pct = 10;
		plan_random_phase(150);
		wait_idle();

		// last part: no stalls
		c.column_set_opcode = 8'h2A;
		c.page_set_opcode = 8'h5B;
		c.memory_write_opcode = 8'hC4;
		c.no_operation_opcode = 8'h81;
		write_opcodes(c);
		idle_pct = 0;
		plan_random_phase(120);
		wait_idle();

		if (expected_words.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived",
				expected_words.size()));
		if (mismatch_count == 0)
			$display("lcd_rect_fill_sequencer_unit test passed");
		else
			$display("lcd_rect_fill_sequencer_unit test failed");
		$finish;
	end

endmodule
